/* rtl/mcbf_pkg.sv */
// ----------------------------------------------------------------------------
// mcbf_pkg
// Shared constants, codes and word types for the multi-channel byte FIFO bank.
// ----------------------------------------------------------------------------
package mcbf_pkg;

    // Bank geometry
    localparam int CHANNELS      = 64;
    localparam int CHANNEL_DEPTH = 4096;

    localparam int CH_W     = $clog2(CHANNELS);
    localparam int PTR_W    = $clog2(CHANNEL_DEPTH);
    localparam int CNT_W    = $clog2(CHANNEL_DEPTH + 1);
    localparam int ADDR_W   = CH_W + PTR_W;
    localparam int STORE_SZ = CHANNELS * (2 ** PTR_W);

    // Operation codes
    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_WRITE  = 3'd2;
    localparam logic [2:0] OP_CLOSE  = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NOFREE = 3'd1;
    localparam logic [2:0] ST_BADCH  = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_EOD    = 3'd4;
    localparam logic [2:0] ST_FULL   = 3'd5;

    // Request word
    typedef struct packed {
        logic [2:0] op;
        logic [5:0] channel;
        logic [7:0] write_data;
        logic       transfer_last;
    } t_in_item;

    // Response word
    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  result_channel;
        logic [7:0]  read_data;
        logic [12:0] fill_count;
        logic        transfer_last_echo;
    } t_out_item;

    // Per-channel pointer context
    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [CNT_W-1:0] occ;
    } t_ctx;

    // State updates decided for one request
    typedef struct packed {
        logic              ctx_we;
        logic [CH_W-1:0]   idx;
        t_ctx              ctx_wdata;
        logic              create;
        logic              wopen_clr;
        logic              store_we;
        logic              store_re;
        logic [ADDR_W-1:0] store_addr;
        logic              take_byte;
    } t_upd;

endpackage

/* rtl/mcbf_ram.sv */
// ----------------------------------------------------------------------------
// mcbf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mcbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mcbf_ctrl.sv */
// ----------------------------------------------------------------------------
// mcbf_ctrl
// Decodes one request against its channel context and decides the response
// and every state update.
// ----------------------------------------------------------------------------
module mcbf_ctrl
    import mcbf_pkg::*;
(
    input  t_in_item            i_item,
    input  t_ctx                i_ctx,
    input  logic [CH_W:0]       i_alloc_count,
    input  logic [CHANNELS-1:0] i_wopen,
    output t_upd                o_upd,
    output t_out_item           o_res
);

    logic             in_range;
    logic             alloc;
    logic [CH_W-1:0]  ch_idx;
    logic [CNT_W-1:0] occ;
    logic             has_free;
    logic [PTR_W-1:0] head_nxt;
    logic [PTR_W-1:0] tail_nxt;

    // Channel checks; channels are claimed in ascending order and never freed
    assign in_range = ({3'b000, i_item.channel} < 9'(CHANNELS));
    assign ch_idx   = CH_W'(i_item.channel);
    assign alloc    = in_range && ((CH_W+1)'(i_item.channel) < i_alloc_count);
    assign occ      = alloc ? i_ctx.occ : '0;
    assign has_free = (i_alloc_count < (CH_W+1)'(CHANNELS));

    // Wrap the ring pointers
    assign head_nxt = (i_ctx.head == PTR_W'(CHANNEL_DEPTH - 1)) ? '0 : i_ctx.head + 1'b1;
    assign tail_nxt = (i_ctx.tail == PTR_W'(CHANNEL_DEPTH - 1)) ? '0 : i_ctx.tail + 1'b1;

    always_comb begin
        o_upd                   = '0;
        o_upd.idx               = ch_idx;
        o_upd.ctx_wdata         = i_ctx;
        o_res                   = '0;
        o_res.status            = ST_BADCH;
        o_res.result_channel    = i_item.channel;
        o_res.transfer_last_echo = i_item.transfer_last;

        unique case (i_item.op)
            OP_CREATE: begin
                o_res.result_channel = '0;
                if (has_free) begin
                    o_res.status         = ST_OK;
                    o_res.result_channel = 6'(i_alloc_count);
                    o_upd.idx            = CH_W'(i_alloc_count);
                    o_upd.ctx_we         = 1'b1;
                    o_upd.ctx_wdata      = '0;
                    o_upd.create         = 1'b1;
                end else begin
                    o_res.status = ST_NOFREE;
                end
            end
            OP_READ: begin
                if (alloc) begin
                    o_res.fill_count = 13'(occ);
                    if (occ == '0) begin
                        o_res.status = i_wopen[ch_idx] ? ST_EMPTY : ST_EOD;
                    end else begin
                        o_res.status         = ST_OK;
                        o_res.fill_count     = 13'(occ - 1'b1);
                        o_upd.ctx_we         = 1'b1;
                        o_upd.ctx_wdata.head = head_nxt;
                        o_upd.ctx_wdata.occ  = occ - 1'b1;
                        o_upd.store_re       = 1'b1;
                        o_upd.store_addr     = {ch_idx, i_ctx.head};
                        o_upd.take_byte      = 1'b1;
                    end
                end
            end
            OP_WRITE: begin
                if (alloc) begin
                    o_res.fill_count = 13'(occ);
                    if (occ == CNT_W'(CHANNEL_DEPTH)) begin
                        o_res.status = ST_FULL;
                    end else begin
                        o_res.status         = ST_OK;
                        o_res.fill_count     = 13'(occ + 1'b1);
                        o_upd.ctx_we         = 1'b1;
                        o_upd.ctx_wdata.tail = tail_nxt;
                        o_upd.ctx_wdata.occ  = occ + 1'b1;
                        o_upd.store_we       = 1'b1;
                        o_upd.store_addr     = {ch_idx, i_ctx.tail};
                    end
                end
            end
            OP_CLOSE: begin
                if (alloc) begin
                    o_res.status     = ST_OK;
                    o_res.fill_count = 13'(occ);
                    o_upd.wopen_clr  = 1'b1;
                end
            end
            OP_QUERY: begin
                if (in_range) begin
                    o_res.status     = ST_OK;
                    o_res.fill_count = 13'(occ);
                end
            end
            default: begin
                o_res.status = ST_BADCH;
            end
        endcase
    end

endmodule

/* rtl/multi_channel_byte_fifo.sv */
// ----------------------------------------------------------------------------
// multi_channel_byte_fifo
// Bank of byte FIFOs sharing one byte store, driven by one operation a word.
// ----------------------------------------------------------------------------
// One request word is taken every clock unless the output stalls, and each
// gives exactly one response word, held in the decode register and then the
// output register. The rate is set by the channel context RAM (head, tail,
// fill count), which is read when a word is accepted and written back as it
// leaves the decode stage; a bypass register covers back-to-back words on the
// same channel. Bytes sit in a shared store of CHANNELS x CHANNEL_DEPTH
// entries whose read data is registered with the response. No clearing pass
// runs after reset: channel contexts are initialised on channel creation,
// and a channel is claimed lowest first and stays claimed until reset.
// ----------------------------------------------------------------------------
module multi_channel_byte_fifo
    import mcbf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic                r_s1_valid;
    t_in_item            r_s1_item;
    logic                r_s2_valid;
    t_out_item           r_s2_res;
    logic                r_s2_take;
    logic                r_fwd_valid;
    logic [CH_W-1:0]     r_fwd_idx;
    t_ctx                r_fwd_ctx;
    logic [CH_W:0]       r_alloc_count;
    logic [CHANNELS-1:0] r_wopen;

    logic                n_s1_valid;
    logic                in_fire;
    logic                s2_adv;
    logic                s2_load;
    t_ctx                ctx_rd;
    t_ctx                ctx_eff;
    t_upd                upd;
    t_out_item           res;
    logic [7:0]          byte_rd;

    // Handshake
    assign s2_adv     = !r_s2_valid || i_out_ready;
    assign s2_load    = r_s1_valid && s2_adv;
    assign o_in_ready = !r_s1_valid || s2_adv;
    assign in_fire    = i_in_valid && o_in_ready;
    assign n_s1_valid = in_fire ? 1'b1 : (s2_load ? 1'b0 : r_s1_valid);

    // Channel context store, read at acceptance
    mcbf_ram #(
        .WIDTH ($bits(t_ctx)),
        .DEPTH (CHANNELS)
    ) u_ctx_ram (
        .i_clk   (i_clk),
        .i_we    (upd.ctx_we && s2_load),
        .i_waddr (upd.idx),
        .i_wdata (upd.ctx_wdata),
        .i_re    (in_fire),
        .i_raddr (CH_W'(i_in_item.channel)),
        .o_rdata (ctx_rd)
    );

    // Bypass the most recent context write
    assign ctx_eff = (r_fwd_valid && (r_fwd_idx == CH_W'(r_s1_item.channel))) ?
                     r_fwd_ctx : ctx_rd;

    mcbf_ctrl u_ctrl (
        .i_item        (r_s1_item),
        .i_ctx         (ctx_eff),
        .i_alloc_count (r_alloc_count),
        .i_wopen       (r_wopen),
        .o_upd         (upd),
        .o_res         (res)
    );

    // Shared byte store
    mcbf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SZ)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (upd.store_we && s2_load),
        .i_waddr (upd.store_addr),
        .i_wdata (r_s1_item.write_data),
        .i_re    (upd.store_re && s2_load),
        .i_raddr (upd.store_addr),
        .o_rdata (byte_rd)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_fwd_valid   <= 1'b0;
            r_alloc_count <= '0;
            r_wopen       <= '0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s2_load && upd.ctx_we) begin
                r_fwd_valid <= 1'b1;
            end
            if (s2_load && upd.create) begin
                r_alloc_count      <= r_alloc_count + 1'b1;
                r_wopen[upd.idx]   <= 1'b1;
            end
            if (s2_load && upd.wopen_clr) begin
                r_wopen[upd.idx] <= 1'b0;
            end
        end
    end

    // Payload: hold the request, advance the response, track the last write
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= i_in_item;
        end
        if (s2_load) begin
            r_s2_res  <= res;
            r_s2_take <= upd.take_byte;
        end
        if (s2_load && upd.ctx_we) begin
            r_fwd_idx <= upd.idx;
            r_fwd_ctx <= upd.ctx_wdata;
        end
    end

    // Response word, byte merged from the store read
    always_comb begin
        o_out_item           = r_s2_res;
        o_out_item.read_data = r_s2_take ? byte_rd : 8'd0;
    end

    assign o_out_valid = r_s2_valid;

endmodule
